// ----- rtl/mfm_pkg.sv -----
// Shared types and constants for the minimum fleet matcher.
// Used by mfm_ctrl, mfm_dp and min_fleet_max_flow_matcher; no dependencies.
package mfm_pkg;

    localparam int DEF_MAX_FLIGHTS = 16;
    localparam int DEF_CITY_BITS   = 8;

    localparam int CITY_W   = 8;
    localparam int MINUTE_W = 11;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    localparam logic [MINUTE_W-1:0] TURN_RESET = 11'd180;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // store the offered record
        logic start;     // last record: clear matching, begin link build
        logic link_row;  // build one row of the link matrix
        logic bfs_init;  // clear visit marks and queue
        logic src_step;  // source scan: one left node
        logic pop;       // take the queue head
        logic lscan;     // left node scan: one right node
        logic rpop;      // handle a popped right node
        logic aug;       // one augment step along the found path
        logic out_step;  // advance the result index
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic v_last;    // scan counter is on the last flight
        logic q_empty;
        logic pop_right; // queue head is a right node
        logic sink_hit;  // popped right node is unmatched
        logic aug_done;  // current left node was reached from the source
        logic out_last;
    } t_sts;

endpackage

// ----- rtl/mfm_ctrl.sv -----
// Sequencer for the minimum fleet matcher: load, link build, search,
// augment and result phases. Depends on mfm_pkg.
module mfm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_flight,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  mfm_pkg::t_sts i_sts,
    output mfm_pkg::t_cmd o_cmd
);
    import mfm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LINK = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_SRC  = 4'd3;
    localparam logic [3:0] S_POP  = 4'd4;
    localparam logic [3:0] S_LSC  = 4'd5;
    localparam logic [3:0] S_RPOP = 4'd6;
    localparam logic [3:0] S_AUG  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_flight) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_LINK;
                    end
                end
            end
            S_LINK: begin
                o_cmd.link_row = 1'b1;
                if (i_sts.v_last) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.bfs_init = 1'b1;
                n_state        = S_SRC;
            end
            S_SRC: begin
                o_cmd.src_step = 1'b1;
                if (i_sts.v_last) n_state = S_POP;
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_sts.pop_right ? S_RPOP : S_LSC;
                end
            end
            S_LSC: begin
                o_cmd.lscan = 1'b1;
                if (i_sts.v_last) n_state = S_POP;
            end
            S_RPOP: begin
                o_cmd.rpop = 1'b1;
                n_state    = i_sts.sink_hit ? S_AUG : S_POP;
            end
            S_AUG: begin
                o_cmd.aug = 1'b1;
                if (i_sts.aug_done) n_state = S_INIT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.out_step = 1'b1;
                    if (i_sts.out_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/mfm_dp.sv -----
// Datapath for the minimum fleet matcher: flight store, link matrix,
// matching, search marks, queue and counters. Depends on mfm_pkg.
module mfm_dp #(
    parameter int MAX_FLIGHTS = mfm_pkg::DEF_MAX_FLIGHTS,
    parameter int CITY_BITS   = mfm_pkg::DEF_CITY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mfm_pkg::MINUTE_W-1:0]   i_cfg_data,
    input  logic [mfm_pkg::CITY_W-1:0]     i_departure_city,
    input  logic [mfm_pkg::CITY_W-1:0]     i_arrival_city,
    input  logic [mfm_pkg::MINUTE_W-1:0]   i_departure_minute,
    input  logic [mfm_pkg::MINUTE_W-1:0]   i_arrival_minute,
    input  mfm_pkg::t_cmd                  i_cmd,
    output mfm_pkg::t_sts                  o_sts,
    output logic [mfm_pkg::INDEX_W-1:0]    o_flight_index,
    output logic                           o_has_next,
    output logic [mfm_pkg::INDEX_W-1:0]    o_next_index,
    output logic [mfm_pkg::COUNT_W-1:0]    o_aircraft_count,
    output logic                           o_last
);
    import mfm_pkg::*;

    localparam int IW  = (MAX_FLIGHTS > 1) ? $clog2(MAX_FLIGHTS) : 1;
    localparam int CW  = $clog2(MAX_FLIGHTS + 1);
    localparam int QD  = 2 * MAX_FLIGHTS;
    localparam int QIW = $clog2(QD);
    localparam int QAW = $clog2(QD + 1);

    logic [MINUTE_W-1:0]  r_turn;
    logic [CITY_BITS-1:0] r_dep_city [MAX_FLIGHTS];
    logic [CITY_BITS-1:0] r_arr_city [MAX_FLIGHTS];
    logic [MINUTE_W-1:0]  r_dep_min  [MAX_FLIGHTS];
    logic [MINUTE_W-1:0]  r_arr_min  [MAX_FLIGHTS];
    logic [MAX_FLIGHTS-1:0] r_link   [MAX_FLIGHTS];
    logic [IW-1:0]        r_lmatch   [MAX_FLIGHTS];
    logic [IW-1:0]        r_rmatch   [MAX_FLIGHTS];
    logic [IW-1:0]        r_par_r    [MAX_FLIGHTS];
    logic [IW-1:0]        r_par_l    [MAX_FLIGHTS];
    logic [MAX_FLIGHTS-1:0] r_par_l_src;
    logic [IW:0]          r_queue    [QD];

    logic [MAX_FLIGHTS-1:0] r_lm_valid, r_rm_valid, r_vis_l, r_vis_r;
    logic [CW-1:0]  r_count, r_flow;
    logic [IW-1:0]  r_v, r_node, r_cur, r_out_idx;
    logic [QAW-1:0] r_head, r_tail;

    logic [CITY_BITS-1:0]   in_dep_city, in_arr_city;
    logic [MINUTE_W:0]      ready_min;
    logic [MAX_FLIGHTS-1:0] link_row;
    logic [IW:0]            q_head;
    logic [IW-1:0]          rp_left, aug_left;
    logic                   ls_hit, rp_push, push;
    logic [IW:0]            push_data;
    logic                   room;

    assign in_dep_city = CITY_BITS'({8'd0, i_departure_city});
    assign in_arr_city = CITY_BITS'({8'd0, i_arrival_city});
    assign room        = r_count < CW'(MAX_FLIGHTS);

    // One row of the link matrix: flight r_v against every other flight in parallel
    always_comb begin
        ready_min = {1'b0, r_arr_min[r_v]} + {1'b0, r_turn};
        for (int b = 0; b < MAX_FLIGHTS; b++) begin
            link_row[b] = (r_v != IW'(b)) && (r_arr_city[r_v] == r_dep_city[b]) &&
                          (ready_min <= {1'b0, r_dep_min[b]});
        end
    end

    always_comb begin
        q_head   = r_queue[r_head[QIW-1:0]];
        rp_left  = r_rmatch[r_node];
        aug_left = r_par_r[r_cur];
        ls_hit   = !r_vis_r[r_v] && r_link[r_node][r_v] &&
                   !(r_lm_valid[r_node] && (r_lmatch[r_node] == r_v));
        rp_push  = r_rm_valid[r_node] && !r_vis_l[rp_left];
        push      = 1'b0;
        push_data = '0;
        if (i_cmd.src_step && !r_lm_valid[r_v]) begin
            push      = 1'b1;
            push_data = {1'b0, r_v};
        end else if (i_cmd.lscan && ls_hit) begin
            push      = 1'b1;
            push_data = {1'b1, r_v};
        end else if (i_cmd.rpop && rp_push) begin
            push      = 1'b1;
            push_data = {1'b0, rp_left};
        end
    end

    always_comb begin
        o_sts.v_last    = (CW'(r_v) + CW'(1)) == r_count;
        o_sts.q_empty   = r_head == r_tail;
        o_sts.pop_right = q_head[IW];
        o_sts.sink_hit  = !r_rm_valid[r_node];
        o_sts.aug_done  = r_par_l_src[aug_left];
        o_sts.out_last  = (CW'(r_out_idx) + CW'(1)) == r_count;
    end

    assign o_flight_index   = INDEX_W'(r_out_idx);
    assign o_has_next       = r_lm_valid[r_out_idx];
    assign o_next_index     = r_lm_valid[r_out_idx] ? INDEX_W'(r_lmatch[r_out_idx]) : '0;
    assign o_aircraft_count = COUNT_W'(r_count - r_flow);
    assign o_last           = o_sts.out_last;

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_dep_city[r_count[IW-1:0]] <= in_dep_city;
            r_arr_city[r_count[IW-1:0]] <= in_arr_city;
            r_dep_min[r_count[IW-1:0]]  <= i_departure_minute;
            r_arr_min[r_count[IW-1:0]]  <= i_arrival_minute;
        end
        if (i_cmd.link_row) r_link[r_v] <= link_row;
        if (push) r_queue[r_tail[QIW-1:0]] <= push_data;
        if (i_cmd.pop) r_node <= q_head[IW-1:0];
        if (i_cmd.src_step && !r_lm_valid[r_v]) r_par_l_src[r_v] <= 1'b1;
        if (i_cmd.lscan && ls_hit) r_par_r[r_v] <= r_node;
        if (i_cmd.rpop) begin
            if (rp_push) begin
                r_par_l_src[rp_left] <= 1'b0;
                r_par_l[rp_left]     <= r_node;
            end
            r_cur <= r_node;
        end
        if (i_cmd.aug) begin
            r_lmatch[aug_left] <= r_cur;
            r_rmatch[r_cur]    <= aug_left;
            r_cur              <= r_par_l[aug_left];
        end
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn     <= TURN_RESET;
            r_count    <= '0;
            r_flow     <= '0;
            r_v        <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_out_idx  <= '0;
            r_lm_valid <= '0;
            r_rm_valid <= '0;
            r_vis_l    <= '0;
            r_vis_r    <= '0;
        end else begin
            if (i_cfg_we) r_turn <= i_cfg_data;
            if (i_cmd.load && room) r_count <= r_count + CW'(1);
            if (i_cmd.start) begin
                r_v        <= '0;
                r_flow     <= '0;
                r_out_idx  <= '0;
                r_lm_valid <= '0;
                r_rm_valid <= '0;
            end
            if (i_cmd.link_row || i_cmd.src_step || i_cmd.lscan) r_v <= r_v + IW'(1);
            if (i_cmd.bfs_init) begin
                r_v     <= '0;
                r_head  <= '0;
                r_tail  <= '0;
                r_vis_l <= '0;
                r_vis_r <= '0;
            end
            if (i_cmd.pop) begin
                r_head <= r_head + QAW'(1);
                r_v    <= '0;
            end
            if (push) r_tail <= r_tail + QAW'(1);
            if (i_cmd.src_step && !r_lm_valid[r_v]) r_vis_l[r_v] <= 1'b1;
            if (i_cmd.lscan && ls_hit) r_vis_r[r_v] <= 1'b1;
            if (i_cmd.rpop && rp_push) r_vis_l[rp_left] <= 1'b1;
            if (i_cmd.aug) begin
                r_lm_valid[aug_left] <= 1'b1;
                r_rm_valid[r_cur]    <= 1'b1;
                if (r_par_l_src[aug_left]) r_flow <= r_flow + CW'(1);
            end
            if (i_cmd.out_step) begin
                if (o_sts.out_last) begin
                    r_out_idx <= '0;
                    r_count   <= '0;
                end else begin
                    r_out_idx <= r_out_idx + IW'(1);
                end
            end
        end
    end

endmodule

// ----- rtl/min_fleet_max_flow_matcher.sv -----
// Minimum fleet matcher top level: controller plus datapath.
// Depends on mfm_pkg, mfm_ctrl and mfm_dp.
//
// Flight records are taken one per cycle and stored until a record marked
// last_flight arrives (records beyond MAX_FLIGHTS are dropped, but a dropped
// last record still starts the run). The block then builds the flight link
// matrix one row per cycle and runs an augmenting-path search over the
// flight matching: each search pass clears the marks, scans every left node
// from the source, scans every right node for each popped left node and
// handles each popped right node; the last pass ends on an empty-queue check,
// and each augmenting path is walked back one left node at a time. While it
// works, the input is stalled. It then delivers one result per flight in
// load order, one per cycle while the output is not stalled, with the
// successor flight and the aircraft count; the last result carries o_last
// and the block returns to loading. min_turnaround resets to 180 and may be
// written while the block is idle.
module min_fleet_max_flow_matcher #(
    parameter int MAX_FLIGHTS = mfm_pkg::DEF_MAX_FLIGHTS,
    parameter int CITY_BITS   = mfm_pkg::DEF_CITY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mfm_pkg::MINUTE_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mfm_pkg::CITY_W-1:0]     i_departure_city,
    input  logic [mfm_pkg::CITY_W-1:0]     i_arrival_city,
    input  logic [mfm_pkg::MINUTE_W-1:0]   i_departure_minute,
    input  logic [mfm_pkg::MINUTE_W-1:0]   i_arrival_minute,
    input  logic                           i_last_flight,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mfm_pkg::INDEX_W-1:0]    o_flight_index,
    output logic                           o_has_next,
    output logic [mfm_pkg::INDEX_W-1:0]    o_next_index,
    output logic [mfm_pkg::COUNT_W-1:0]    o_aircraft_count,
    output logic                           o_last
);
    import mfm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence the phases; hold the input while a batch is in flight
    mfm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_flight (i_last_flight),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // Store records, build links, search and augment, drive the result fields
    mfm_dp #(
        .MAX_FLIGHTS (MAX_FLIGHTS),
        .CITY_BITS   (CITY_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_departure_city   (i_departure_city),
        .i_arrival_city     (i_arrival_city),
        .i_departure_minute (i_departure_minute),
        .i_arrival_minute   (i_arrival_minute),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_flight_index     (o_flight_index),
        .o_has_next         (o_has_next),
        .o_next_index       (o_next_index),
        .o_aircraft_count   (o_aircraft_count),
        .o_last             (o_last)
    );

endmodule
